[hw/rtl/led_matrix_bitplane_scanner_core_macros.svh]
// Assertion macros for the LED matrix bit-plane scanner checker.
// Depends on nothing; the including scope provides clk and rst_n.
`ifndef LED_MATRIX_BITPLANE_SCANNER_CORE_MACROS_SVH
`define LED_MATRIX_BITPLANE_SCANNER_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk, off while reset is asserted.
`define LMBS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while reset is asserted.
`define LMBS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/lmbs_pkg.sv]
// Shared types and constants for the LED matrix bit-plane scanner.
// Used by the core and its port checker; no dependencies.
package lmbs_pkg;

  localparam int DEF_ROWS    = 8;
  localparam int DEF_PLANES  = 3;

  localparam int COL_W       = 7;
  localparam int ROW_W       = 4;
  localparam int PLANE_W     = 2;
  localparam int DWELL_W     = 8;
  localparam int CFG_IDX_W   = 2;
  localparam int ADDR_FULL_W = 6;

  localparam logic [DWELL_W-1:0] DWELL_AT_RESET = 8'd21;
  localparam logic [DWELL_W-1:0] DWELL0_RESET   = 8'd12;
  localparam logic [DWELL_W-1:0] DWELL1_RESET   = 8'd20;
  localparam logic [DWELL_W-1:0] DWELL2_RESET   = 8'd50;

  // Request kinds carried on in_tuser.
  typedef enum logic {
    REQ_TICK  = 1'b0,
    REQ_WRITE = 1'b1
  } req_type_t;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PLANE0_DWELL = 2'd0,
    CFG_PLANE1_DWELL = 2'd1,
    CFG_PLANE2_DWELL = 2'd2
  } cfg_idx_t;

  // Result payload; column_drive sits in the lowest bits.
  typedef struct packed {
    logic [PLANE_W-1:0] shown_plane;
    logic [ROW_W-1:0]   shown_row;
    logic               row_shift_data;
    logic [COL_W-1:0]   column_drive;
  } result_t;

  // Request state waiting on the frame store read.
  typedef struct packed {
    logic               show;
    logic               shift_data;
    logic [ROW_W-1:0]   shown_row;
    logic [PLANE_W-1:0] shown_plane;
  } pend_t;

endpackage

[hw/rtl/led_matrix_bitplane_scanner_core.sv]
// LED matrix bit-plane scanner core: frame store, dwell timer and row scan.
// Depends on lmbs_pkg.
//
//  Channel | Ports                          | Contents
//  --------+--------------------------------+--------------------------------------
//  in      | in_tvalid/in_tready/in_tdata   | tick or frame store write request
//  out     | out_tvalid/out_tready/out_tdata| column drive and scan status per request
//  cfg     | cfg_wr_en/cfg_index/cfg_wdata  | per-plane dwell registers, write only
//
// One request per cycle sustained unless out stalls; each request yields one result
// through the frame store read and pending stage, then the output register.
// The frame store is a one-read, one-write synchronous memory; per-entry valid
// bits cleared by reset make unwritten entries read as zero, so no clearing pass.
// Reset is synchronous, active low. A stall on out backs up through the
// pending stage; in_tready drops only when both stages are full.
module led_matrix_bitplane_scanner_core
  import lmbs_pkg::*;
#(
  parameter int ROWS   = DEF_ROWS,
  parameter int PLANES = DEF_PLANES
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  // [1:0] write_plane, [5:2] write_row, [12:6] write_columns, [15:13] zero
  input  logic [15:0]          in_tdata,
  // [0] req_type
  input  logic                 in_tuser,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  // [6:0] column_drive, [7] row_shift_data, [11:8] shown_row,
  // [13:12] shown_plane, [15:14] zero
  output logic [15:0]          out_tdata,
  // [0] row_advanced
  output logic                 out_tuser,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DWELL_W-1:0]   cfg_wdata
);

  localparam int DEPTH  = ROWS * PLANES;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // Dwell registers.
  logic [DWELL_W-1:0] dwell0_r, dwell1_r, dwell2_r;

  // Scan state.
  logic [ROW_W-1:0]   next_row_r, next_row_nxt;
  logic [PLANE_W-1:0] next_plane_r, next_plane_nxt;
  logic [DWELL_W-1:0] dwell_left_r, dwell_left_nxt;
  logic [ROW_W-1:0]   shown_row_r, shown_row_nxt;
  logic [PLANE_W-1:0] shown_plane_r, shown_plane_nxt;
  logic [COL_W-1:0]   cols_r;

  // Frame store.
  logic [COL_W-1:0]   mem [DEPTH];
  logic [DEPTH-1:0]   mem_valid_r;
  logic [COL_W-1:0]   rd_data_r;
  logic               rd_valid_r;

  // Pipeline.
  pend_t              pend_r, pend_nxt;
  logic               pend_valid_r;
  result_t            res_r;
  logic               res_adv_r;
  logic               out_valid_r;

  // Request decode.
  req_type_t          req;
  logic [PLANE_W-1:0] wr_plane;
  logic [ROW_W-1:0]   wr_row;
  logic [COL_W-1:0]   wr_cols;
  logic               in_acc, is_write, wr_en, show;
  logic               out_free, pend_move;
  logic [DWELL_W-1:0] dwell_dec, dwell_sel;
  logic               row_last, plane_last;
  logic [ADDR_FULL_W-1:0] rd_addr_full, wr_addr_full;
  logic [ADDR_W-1:0]  rd_addr, wr_addr;
  logic [COL_W-1:0]   show_cols;

  assign req      = req_type_t'(in_tuser);
  assign wr_plane = in_tdata[1:0];
  assign wr_row   = in_tdata[5:2];
  assign wr_cols  = in_tdata[12:6];

  // Handshake: output register frees when taken; pending stage moves into it.
  assign out_free  = !out_valid_r || out_tready;
  assign pend_move = pend_valid_r && out_free;
  assign in_tready = !pend_valid_r || pend_move;
  assign in_acc    = in_tvalid && in_tready;
  assign is_write  = (req == REQ_WRITE);

  // Drop writes outside the stored planes and rows.
  assign wr_en = in_acc && is_write &&
                 ({1'b0, wr_plane} < (PLANE_W + 1)'(PLANES)) &&
                 ({1'b0, wr_row} < (ROW_W + 1)'(ROWS));

  assign wr_addr_full = ADDR_FULL_W'(wr_plane) * ADDR_FULL_W'(ROWS) +
                        ADDR_FULL_W'(wr_row);
  assign rd_addr_full = ADDR_FULL_W'(next_plane_r) * ADDR_FULL_W'(ROWS) +
                        ADDR_FULL_W'(next_row_r);
  assign wr_addr = wr_addr_full[ADDR_W-1:0];
  assign rd_addr = rd_addr_full[ADDR_W-1:0];

  assign dwell_dec  = dwell_left_r - DWELL_W'(1);
  assign show       = in_acc && !is_write && (dwell_dec == '0);
  assign row_last   = (next_row_r == ROW_W'(ROWS - 1));
  assign plane_last = (next_plane_r == PLANE_W'(PLANES - 1));

  // Reload value for the plane about to be shown.
  always_comb begin
    case (next_plane_r)
      PLANE_W'(0): dwell_sel = dwell0_r;
      PLANE_W'(1): dwell_sel = dwell1_r;
      default:     dwell_sel = dwell2_r;
    endcase
  end

  // Advance scan counters on a tick; reload and step row/plane on expiry.
  always_comb begin
    next_row_nxt    = next_row_r;
    next_plane_nxt  = next_plane_r;
    dwell_left_nxt  = dwell_left_r;
    shown_row_nxt   = shown_row_r;
    shown_plane_nxt = shown_plane_r;
    if (in_acc && !is_write) begin
      dwell_left_nxt = dwell_dec;
    end
    if (show) begin
      dwell_left_nxt  = dwell_sel;
      shown_row_nxt   = next_row_r;
      shown_plane_nxt = next_plane_r;
      if (row_last) begin
        next_row_nxt   = '0;
        next_plane_nxt = plane_last ? '0 : next_plane_r + PLANE_W'(1);
      end else begin
        next_row_nxt = next_row_r + ROW_W'(1);
      end
    end
  end

  // Capture what the result needs besides the frame store data.
  always_comb begin
    pend_nxt.show        = show;
    pend_nxt.shift_data  = show && (next_row_r == '0);
    pend_nxt.shown_row   = shown_row_nxt;
    pend_nxt.shown_plane = shown_plane_nxt;
  end

  // Never-written entries read as all columns off.
  assign show_cols = pend_r.show ? (rd_valid_r ? rd_data_r : '0) : cols_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dwell0_r <= DWELL0_RESET;
      dwell1_r <= DWELL1_RESET;
      dwell2_r <= DWELL2_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_PLANE0_DWELL: dwell0_r <= cfg_wdata;
        CFG_PLANE1_DWELL: dwell1_r <= cfg_wdata;
        CFG_PLANE2_DWELL: dwell2_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      next_row_r    <= '0;
      next_plane_r  <= '0;
      dwell_left_r  <= DWELL_AT_RESET;
      shown_row_r   <= '0;
      shown_plane_r <= '0;
    end else begin
      next_row_r    <= next_row_nxt;
      next_plane_r  <= next_plane_nxt;
      dwell_left_r  <= dwell_left_nxt;
      shown_row_r   <= shown_row_nxt;
      shown_plane_r <= shown_plane_nxt;
    end
  end

  // Frame store: one write and one registered read per cycle. Read data is used only
  // for a tick, and a tick never writes, so no same-cycle bypass is needed.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_cols;
    end
    if (in_acc) begin
      rd_data_r  <= mem[rd_addr];
      rd_valid_r <= mem_valid_r[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mem_valid_r <= '0;
    end else if (wr_en) begin
      mem_valid_r[wr_addr] <= 1'b1;
    end
  end

  // Pending stage and output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
      cols_r       <= '0;
    end else begin
      if (in_acc) begin
        pend_valid_r <= 1'b1;
      end else if (pend_move) begin
        pend_valid_r <= 1'b0;
      end
      if (pend_move) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (pend_move && pend_r.show) begin
        cols_r <= show_cols;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      pend_r <= pend_nxt;
    end
    if (pend_move) begin
      res_r.column_drive   <= show_cols;
      res_r.row_shift_data <= pend_r.shift_data;
      res_r.shown_row      <= pend_r.shown_row;
      res_r.shown_plane    <= pend_r.shown_plane;
      res_adv_r            <= pend_r.show;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, res_r};
  assign out_tuser  = res_adv_r;

endmodule

[hw/rtl/lmbs_checker.sv]
// Port-level checker for the LED matrix bit-plane scanner core, bound to it.
// Depends on lmbs_pkg and led_matrix_bitplane_scanner_core_macros.svh.
`include "led_matrix_bitplane_scanner_core_macros.svh"

module lmbs_checker
  import lmbs_pkg::*;
(
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_tvalid,
  input logic                 in_tready,
  input logic                 out_tvalid,
  input logic                 out_tready,
  input logic [15:0]          out_tdata,
  input logic                 out_tuser
);

  // Hold a stalled result.
  `LMBS_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser), "stalled result changed")

  // With the output empty the pending stage drains, so a request is taken.
  `LMBS_ASSERT_NOW(a_ready_when_empty, !out_tvalid, in_tready, "input blocked with empty output")

  // Shift data only comes with a shown row, and only for row zero.
  `LMBS_ASSERT_NOW(a_shift_needs_show, out_tvalid && out_tdata[7], out_tuser && (out_tdata[11:8] == 4'd0), "shift data without a shown row zero")

  // The shown plane never exceeds the last plane.
  `LMBS_ASSERT_NOW(a_plane_range, out_tvalid, out_tdata[13:12] != 2'd3, "shown plane out of range")

endmodule

bind led_matrix_bitplane_scanner_core lmbs_checker u_lmbs_checker (.*);

[dv/led_matrix_bitplane_scanner_core_tb.sv]
// Self-checking testbench for led_matrix_bitplane_scanner_core: drives tick and
// frame store write requests, predicts every result and compares it field by field.
// Depends on lmbs_pkg and the core RTL only.
`timescale 1ns / 100ps

module led_matrix_bitplane_scanner_core_tb;
  import lmbs_pkg::*;

  // Index past the last dwell register; writes to it must change nothing.
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 2'd3;
  // Quiet cycles (no request and no result moving) before the run is declared hung.
  localparam int QUIET_LIMIT = 1000;
  // Result latency of the core plus margin, waited out once at the end.
  localparam int TAIL_CYCLES = 8;

  // Predicts the scan and holds the results still owed by the core.
  class scan_scoreboard;
    typedef struct packed {
      result_t payload;
      logic    advanced;
    } scan_result_t;

    logic [DWELL_W-1:0] dwell_reg [DEF_PLANES];
    logic [COL_W-1:0]   frame_store [DEF_PLANES][DEF_ROWS];
    logic [ROW_W-1:0]   next_row;
    logic [PLANE_W-1:0] next_plane;
    logic [DWELL_W-1:0] dwell_left;
    logic [COL_W-1:0]   columns_out;
    logic [ROW_W-1:0]   shown_row;
    logic [PLANE_W-1:0] shown_plane;
    scan_result_t       owed_results [$];
    int mismatches, checked, ticks, writes, ignored_writes, rows_shown;

    function new();
      dwell_reg[0] = DWELL0_RESET;
      dwell_reg[1] = DWELL1_RESET;
      dwell_reg[2] = DWELL2_RESET;
      foreach (frame_store[p, r]) frame_store[p][r] = '0;
      next_row    = '0;
      next_plane  = '0;
      dwell_left  = DWELL_AT_RESET;
      columns_out = '0;
      shown_row   = '0;
      shown_plane = '0;
    endfunction

    function void set_dwell(logic [CFG_IDX_W-1:0] idx, logic [DWELL_W-1:0] value);
      case (idx)
        CFG_PLANE0_DWELL: dwell_reg[0] = value;
        CFG_PLANE1_DWELL: dwell_reg[1] = value;
        CFG_PLANE2_DWELL: dwell_reg[2] = value;
        default: ;
      endcase
    endfunction

    function int pending();
      return owed_results.size();
    endfunction

    // Advance the prediction by one accepted request and queue its result.
    function void note_request(logic kind, logic [15:0] payload);
      logic [PLANE_W-1:0] plane;
      logic [ROW_W-1:0]   row;
      scan_result_t       res;
      plane = payload[1:0];
      row   = payload[5:2];
      res   = '0;
      if (kind == REQ_WRITE) begin
        writes++;
        if (plane < DEF_PLANES && row < DEF_ROWS) frame_store[plane][row] = payload[12:6];
        else ignored_writes++;
      end else begin
        ticks++;
        dwell_left = dwell_left - 1'b1;
        if (dwell_left == '0) begin
          // Show the pending entry, reload from its plane, then step row and plane.
          rows_shown++;
          res.payload.row_shift_data = (next_row == '0);
          res.advanced = 1'b1;
          dwell_left   = dwell_reg[next_plane];
          columns_out  = frame_store[next_plane][next_row];
          shown_row    = next_row;
          shown_plane  = next_plane;
          if (next_row == DEF_ROWS - 1) begin
            next_row   = '0;
            next_plane = (next_plane == DEF_PLANES - 1) ? '0 : next_plane + 1'b1;
          end else begin
            next_row = next_row + 1'b1;
          end
        end
      end
      res.payload.column_drive = columns_out;
      res.payload.shown_row    = shown_row;
      res.payload.shown_plane  = shown_plane;
      owed_results.push_back(res);
    endfunction

    task report_mismatch(string what);
      mismatches++;
      if (mismatches <= 40) $display("[%0t] MISMATCH: %s", $time, what);
    endtask

    task check_result(logic [15:0] data, logic advanced);
      result_t      got;
      scan_result_t want;
      got = data[$bits(result_t)-1:0];
      if (owed_results.size() == 0) begin
        report_mismatch($sformatf("result %h/%b with nothing expected", data, advanced));
      end else begin
        want = owed_results.pop_front();
        if (got.column_drive !== want.payload.column_drive)
          report_mismatch($sformatf("result %0d column_drive %h, want %h", checked,
                                    got.column_drive, want.payload.column_drive));
        if (got.row_shift_data !== want.payload.row_shift_data)
          report_mismatch($sformatf("result %0d row_shift_data %b, want %b", checked,
                                    got.row_shift_data, want.payload.row_shift_data));
        if (got.shown_row !== want.payload.shown_row)
          report_mismatch($sformatf("result %0d shown_row %0d, want %0d", checked,
                                    got.shown_row, want.payload.shown_row));
        if (got.shown_plane !== want.payload.shown_plane)
          report_mismatch($sformatf("result %0d shown_plane %0d, want %0d", checked,
                                    got.shown_plane, want.payload.shown_plane));
        if (advanced !== want.advanced)
          report_mismatch($sformatf("result %0d row_advanced %b, want %b", checked,
                                    advanced, want.advanced));
      end
      checked++;
    endtask
  endclass

  // All inputs start at known values; stimulus changes them only at falling edges.
  logic                 clk        = 1'b0;
  logic                 rst_n      = 1'b0;
  logic                 in_tvalid  = 1'b0;
  logic                 in_tready;
  logic [15:0]          in_tdata   = '0;
  logic                 in_tuser   = 1'b0;
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [15:0]          out_tdata;
  logic                 out_tuser;
  logic                 cfg_wr_en  = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index  = '0;
  logic [DWELL_W-1:0]   cfg_wdata  = '0;

  scan_scoreboard sb = new();
  int quiet_cycles = 0;
  int ready_run    = 0;
  int burst_left   = 0;
  int phases_run   = 0;

  led_matrix_bitplane_scanner_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    // [1:0] write_plane, [5:2] write_row, [12:6] write_columns, [15:13] zero
    .in_tdata   (in_tdata),
    // [0] req_type
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    // [6:0] column_drive, [7] row_shift_data, [11:8] shown_row, [13:12] shown_plane
    .out_tdata  (out_tdata),
    // [0] row_advanced
    .out_tuser  (out_tuser),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always #5 clk = ~clk;

  // Sample both channels at the rising edge: check the result first, then note the
  // request. A result never belongs to the request accepted at the same edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) sb.check_result(out_tdata, out_tuser);
      if (in_tvalid && in_tready) sb.note_request(in_tuser, in_tdata);
    end
  end

  // Watchdog: end the run when nothing moves for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Timeout: no request or result for %0d cycles", QUIET_LIMIT);
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Receiver: alternate ready and stall runs; short stalls mostly, a long one now and
  // then, and long ready stretches so the pipeline also runs without back-pressure.
  always @(negedge clk) begin
    if (ready_run > 0) begin
      ready_run <= ready_run - 1;
    end else if (out_tready) begin
      out_tready <= 1'b0;
      ready_run  <= ($urandom_range(0, 7) == 0) ? $urandom_range(5, 25) : $urandom_range(0, 3);
    end else begin
      out_tready <= 1'b1;
      ready_run  <= $urandom_range(0, 40);
    end
  end

  // Present one request and hold it until accepted; return at the next falling edge.
  task automatic send_request(logic kind, logic [PLANE_W-1:0] plane, logic [ROW_W-1:0] row,
                              logic [COL_W-1:0] cols);
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {3'b000, cols, row, plane};
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  task automatic send_ticks(int count);
    repeat (count) send_request(REQ_TICK, '0, '0, '0);
  endtask

  task automatic pause(int cycles);
    in_tvalid <= 1'b0;
    repeat (cycles) @(negedge clk);
  endtask

  // Hold off the sender until every owed result has come back.
  task automatic drain();
    if (sb.pending() != 0) begin
      in_tvalid <= 1'b0;
      while (sb.pending() != 0) @(negedge clk);
    end
  endtask

  // Program all three dwell registers back to back, optionally poking the unused index.
  task automatic program_dwells(logic [DWELL_W-1:0] d0, logic [DWELL_W-1:0] d1,
                                logic [DWELL_W-1:0] d2, bit poke_unused);
    logic [DWELL_W-1:0] vals [4];
    logic [CFG_IDX_W-1:0] idxs [4];
    int n;
    vals = '{d0, d1, d2, 8'hA5};
    idxs = '{CFG_PLANE0_DWELL, CFG_PLANE1_DWELL, CFG_PLANE2_DWELL, CFG_UNUSED_IDX};
    n = poke_unused ? 4 : 3;
    for (int i = 0; i < n; i++) begin
      cfg_wr_en <= 1'b1;
      cfg_index <= idxs[i];
      cfg_wdata <= vals[i];
      sb.set_dwell(idxs[i], vals[i]);
      @(negedge clk);
    end
    cfg_wr_en <= 1'b0;
    @(negedge clk);
  endtask

  // Random mix of ticks and writes, sent in bursts with gaps in between.
  task automatic run_random(int count, int tick_pct);
    logic               kind;
    logic [PLANE_W-1:0] plane;
    logic [ROW_W-1:0]   row;
    int                 pick;
    for (int i = 0; i < count; i++) begin
      if (burst_left == 0) begin
        // Drop valid between bursts; a third of the time chain bursts back to back.
        if ($urandom_range(0, 2) != 0) pause($urandom_range(1, 4));
        burst_left = $urandom_range(1, 24);
      end
      burst_left--;
      // Occasionally stop and let the core empty out completely.
      if ($urandom_range(0, 99) == 0) drain();
      kind = ($urandom_range(0, 99) < tick_pct) ? REQ_TICK : REQ_WRITE;
      pick = $urandom_range(0, 9);
      if (pick < 2) begin
        // Aim at the entry on the columns now or the one shown next.
        plane = (pick == 0) ? sb.shown_plane : sb.next_plane;
        row   = (pick == 0) ? sb.shown_row : sb.next_row;
      end else begin
        plane = (pick == 2) ? 2'd3 : 2'($urandom_range(0, DEF_PLANES - 1));
        row   = (pick == 3) ? 4'($urandom_range(DEF_ROWS, 15))
                            : 4'($urandom_range(0, DEF_ROWS - 1));
      end
      send_request(kind, plane, row, 7'($urandom_range(0, 127)));
    end
  endtask

  initial begin
    // Hold reset, then release it at a falling edge.
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: store extremes, writes outside the matrix, the wait before the first
    // show, then overwrite the entry just shown and confirm the columns hold.
    send_request(REQ_WRITE, 2'd0, 4'd0, 7'h7F);
    send_request(REQ_WRITE, 2'd2, 4'd7, 7'h55);
    send_request(REQ_WRITE, 2'd1, 4'd1, 7'h00);
    send_request(REQ_WRITE, 2'd3, 4'd7, 7'h7F);
    send_request(REQ_WRITE, 2'd0, 4'd15, 7'h7F);
    send_request(REQ_WRITE, 2'd1, 4'd8, 7'h01);
    send_ticks(int'(DWELL_AT_RESET));
    send_request(REQ_WRITE, 2'd0, 4'd0, 7'h00);
    send_ticks(2);
    drain();

    // Fastest scan: once the running dwell expires, every tick shows a row, so all rows and planes cycle through.
    program_dwells(8'd1, 8'd1, 8'd1, 1'b0);
    phases_run++;
    run_random(50, 75);
    drain();

    // Uneven dwells and a write to the index past the register file.
    program_dwells(8'd3, 8'd7, 8'd2, 1'b1);
    phases_run++;
    run_random(40, 70);
    drain();

    // Longest dwells: 255 ticks, and zero wrapping to 256 ticks.
    program_dwells(8'd255, 8'd0, 8'd0, 1'b0);
    phases_run++;
    run_random(280, 95);
    drain();

    program_dwells(8'd2, 8'd1, 8'd4, 1'b0);
    phases_run++;
    run_random(30, 60);
    drain();

    // Let the pipeline settle; any stray result shows up as unexpected.
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Covered %0d ticks and %0d frame store writes (%0d outside the matrix)",
             sb.ticks, sb.writes, sb.ignored_writes);
    $display("%0d rows shown over %0d dwell settings, %0d results checked, %0d mismatches",
             sb.rows_shown, phases_run, sb.checked, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
